FILE: hw/rtl/dtdt_pkg.sv
// ============================================================================
// dtdt_pkg: shared constants and types for the double to decimal text block
// Holds the ASCII codes, float field limits and the BCD converter control.
// ============================================================================
package dtdt_pkg;

	localparam int INTEGER_DIGITS_DEF  = 18;
	localparam int FRACTION_DIGITS_DEF = 16;

	localparam int MANT_W    = 53;   // significand with hidden bit
	localparam int EXP_W     = 11;
	localparam int SCALE_W   = 11;   // binary point position, up to 1074
	localparam int PROD_W    = 57;   // significand times ten
	localparam int INT_CNT_W = 6;    // integer bits to convert, up to 60

	localparam logic [7:0] CHAR_NONE  = 8'h00;
	localparam logic [7:0] CHAR_MINUS = 8'h2D;
	localparam logic [7:0] CHAR_DOT   = 8'h2E;
	localparam logic [7:0] CHAR_ZERO  = 8'h30;

	localparam logic [EXP_W-1:0]   EXP_SPECIAL = 11'h7FF;
	localparam logic [EXP_W-1:0]   EXP_BIG     = 11'd1082;  // beyond this ip >= 2^60
	localparam logic [SCALE_W-1:0] SCALE_MAX   = 11'd1074;
	localparam logic [SCALE_W-1:0] SCALE_FRAC  = 11'd53;

	// Control of the BCD register from the sequencer.
	typedef struct packed {
		logic clear;   // zero the digits and the overflow flag
		logic dabble;  // add-3 correct, then shift in bit_in
		logic bit_in;
		logic pop;     // shift out the top digit
	} bcd_ctrl_t;

endpackage

FILE: hw/rtl/double_to_decimal_text.sv
// ============================================================================
// double_to_decimal_text: IEEE binary64 to decimal ASCII text
// One 64-bit pattern in, its text out one character per transaction.
// ============================================================================
// Usage: present a binary64 bit pattern on value_bits with in_valid; it is
// taken when in_ready is high, which happens only while the converter is
// idle. The text comes out as one character per out transaction: an
// optional '-', the integer digits without leading zeros, '.', then
// FRACTION_DIGITS fraction digits; last marks the final character. NaN,
// infinity or an integer part of 10^INTEGER_DIGITS or more give a single
// transaction with character 0, last and error set.
// Sequence: the integer bits go through the bit-serial BCD converter, one bit
// per cycle, and then the overflow flag is checked. Each integer digit
// position is then emitted or skipped in turn. Each fraction digit passes
// through normalize check, times ten, then round and emit, with one
// normalize shift for each leading zero bit shifted out, at most 52.
// The next number is taken once the last character sits in the output
// register, even while the receiver still holds it. A stalled receiver
// freezes the sequencer at the next character; nothing is dropped.
// Reset clears the sequencer and the output register: no transaction pending.
// ============================================================================
module double_to_decimal_text #(
	parameter int INTEGER_DIGITS  = dtdt_pkg::INTEGER_DIGITS_DEF,
	parameter int FRACTION_DIGITS = dtdt_pkg::FRACTION_DIGITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [63:0] value_bits,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  character,
	output logic        last,
	output logic        error
);

	localparam int ICNT_W = $clog2(INTEGER_DIGITS + 1);
	localparam int FCNT_W = $clog2(FRACTION_DIGITS + 1);
	localparam int MW     = dtdt_pkg::MANT_W;
	localparam int SW     = dtdt_pkg::SCALE_W;
	localparam int PW     = dtdt_pkg::PROD_W;

	typedef enum logic [3:0] {
		ST_IDLE, ST_CONV, ST_ERR, ST_SIGN, ST_IDIG, ST_DOT,
		ST_FNORM, ST_FMUL, ST_FRND
	} state_t;

	state_t state_q;

	// fraction significand and binary point: value = x_q * 2^-s_q
	logic [MW-1:0]                     x_q;
	logic [SW-1:0]                     s_q;
	logic [dtdt_pkg::INT_CNT_W-1:0]    cnt_q;
	logic                              neg_q;
	logic [ICNT_W-1:0]                 idig_q;
	logic                              seen_q;
	logic [FCNT_W-1:0]                 fcnt_q;
	logic [MW-1:0]                     keep_q;
	logic                              rnd_q;

	logic [7:0] char_q;
	logic       last_q;
	logic       err_q;
	logic       valid_q;

	logic accept;
	logic slot_free;
	logic load_char;

	assign in_ready  = (state_q == ST_IDLE);
	assign accept    = in_valid && in_ready;
	assign slot_free = !valid_q || out_ready;

	// ---- input decode ----
	logic [dtdt_pkg::EXP_W-1:0]     exp_f;
	logic [51:0]                    frac_f;
	logic                           is_special;
	logic                           too_big;
	logic [MW-1:0]                  mant;
	logic signed [11:0]             sh;
	logic signed [11:0]             nint_full;
	logic [dtdt_pkg::INT_CNT_W-1:0] n_int;
	logic [SW-1:0]                  s_init;
	logic                           is_neg;

	always_comb begin
		exp_f      = value_bits[62:52];
		frac_f     = value_bits[51:0];
		is_special = (exp_f == dtdt_pkg::EXP_SPECIAL);
		too_big    = (exp_f > dtdt_pkg::EXP_BIG);
		mant       = {(exp_f != '0), frac_f};
		if (exp_f == '0) begin
			sh = 12'sd1074;
		end else begin
			sh = 12'sd1075 - $signed({1'b0, exp_f});
		end
		nint_full = 12'sd53 - sh;
		// bits above the binary point feed the BCD converter
		if (sh < 12'sd53) begin
			n_int  = nint_full[dtdt_pkg::INT_CNT_W-1:0];
			s_init = dtdt_pkg::SCALE_FRAC;
		end else begin
			n_int  = '0;
			s_init = sh[SW-1:0];
		end
		is_neg = value_bits[63] && ((exp_f != '0) || (frac_f != '0));
	end

	// ---- BCD converter ----
	dtdt_pkg::bcd_ctrl_t bcd_ctrl;
	logic [3:0]          top_digit;
	logic                bcd_ovf;
	logic                idig_emit;

	assign idig_emit = (top_digit != 4'd0) || seen_q || (idig_q == '0);

	always_comb begin
		bcd_ctrl.clear  = accept;
		bcd_ctrl.dabble = (state_q == ST_CONV) && (cnt_q != '0);
		bcd_ctrl.bit_in = x_q[MW-1];
		bcd_ctrl.pop    = (state_q == ST_IDIG) && (!idig_emit || slot_free);
	end

	dtdt_bcd #(
		.DIGITS (INTEGER_DIGITS)
	) u_bcd (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (bcd_ctrl),
		.top_digit (top_digit),
		.overflow  (bcd_ovf)
	);

	// ---- times-ten step, first half: product and round decision ----
	logic [PW-1:0] prod;
	logic [PW-1:0] prod_sh;
	logic [2:0]    k;
	logic          guard;
	logic          sticky;
	logic          rnd;

	always_comb begin
		prod = ({4'b0, x_q} << 3) + ({4'b0, x_q} << 1);
		if (prod[56]) begin
			k = 3'd4;
		end else if (prod[55]) begin
			k = 3'd3;
		end else if (prod[54]) begin
			k = 3'd2;
		end else if (prod[53]) begin
			k = 3'd1;
		end else begin
			k = 3'd0;
		end
		prod_sh = prod >> k;
		case (k)
			3'd1: begin
				guard  = prod[0];
				sticky = 1'b0;
			end
			3'd2: begin
				guard  = prod[1];
				sticky = prod[0];
			end
			3'd3: begin
				guard  = prod[2];
				sticky = |prod[1:0];
			end
			3'd4: begin
				guard  = prod[3];
				sticky = |prod[2:0];
			end
			default: begin
				guard  = 1'b0;
				sticky = 1'b0;
			end
		endcase
		// round to nearest, ties to even
		rnd = guard && (sticky || prod_sh[0]);
	end

	// ---- second half: increment, digit extraction, remainder ----
	logic [MW:0]   sum;
	logic [MW-1:0] kept;
	logic [SW-1:0] s_adj;
	logic [3:0]    digit_raw;
	logic [3:0]    digit;
	logic [MW-1:0] rem;

	always_comb begin
		sum = {1'b0, keep_q} + {{MW{1'b0}}, rnd_q};
		if (sum[MW]) begin
			kept  = sum[MW:1];
			s_adj = s_q - 11'd1;
		end else begin
			kept  = sum[MW-1:0];
			s_adj = s_q;
		end
		rem = kept;
		case (s_adj)
			11'd49: begin
				digit_raw = kept[52:49];
				// a product rounded up to ten keeps one after the nine
				rem[52:49] = (kept[52:49] > 4'd9) ? (kept[52:49] - 4'd9) : 4'd0;
			end
			11'd50: begin
				digit_raw = {1'b0, kept[52:50]};
				rem[52:50] = 3'd0;
			end
			11'd51: begin
				digit_raw = {2'b0, kept[52:51]};
				rem[52:51] = 2'd0;
			end
			11'd52: begin
				digit_raw = {3'b0, kept[52]};
				rem[52] = 1'b0;
			end
			default: begin
				digit_raw = 4'd0;
			end
		endcase
		digit = (digit_raw > 4'd9) ? 4'd9 : digit_raw;
	end

	// ---- sequencer and output register ----
	assign load_char = slot_free && ((state_q == ST_ERR) || (state_q == ST_SIGN) ||
		(state_q == ST_DOT) || (state_q == ST_FRND) ||
		((state_q == ST_IDIG) && idig_emit));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			x_q     <= '0;
			s_q     <= '0;
			cnt_q   <= '0;
			neg_q   <= 1'b0;
			idig_q  <= '0;
			seen_q  <= 1'b0;
			fcnt_q  <= '0;
			keep_q  <= '0;
			rnd_q   <= 1'b0;
			char_q  <= '0;
			last_q  <= 1'b0;
			err_q   <= 1'b0;
			valid_q <= 1'b0;
		end else begin
			// drop the held character once the receiver takes it and none replaces it
			if (valid_q && out_ready && !load_char) begin
				valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						x_q    <= mant;
						s_q    <= s_init;
						cnt_q  <= n_int;
						neg_q  <= is_neg;
						idig_q <= ICNT_W'(INTEGER_DIGITS - 1);
						seen_q <= 1'b0;
						state_q <= (is_special || too_big) ? ST_ERR : ST_CONV;
					end
				end
				ST_CONV: begin
					if (cnt_q != '0) begin
						// advance one integer bit into the BCD register
						x_q   <= x_q << 1;
						cnt_q <= cnt_q - dtdt_pkg::INT_CNT_W'(1);
					end else if (bcd_ovf) begin
						state_q <= ST_ERR;
					end else begin
						state_q <= neg_q ? ST_SIGN : ST_IDIG;
					end
				end
				ST_ERR: begin
					if (slot_free) begin
						char_q  <= dtdt_pkg::CHAR_NONE;
						last_q  <= 1'b1;
						err_q   <= 1'b1;
						valid_q <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				ST_SIGN: begin
					if (slot_free) begin
						char_q  <= dtdt_pkg::CHAR_MINUS;
						last_q  <= 1'b0;
						err_q   <= 1'b0;
						valid_q <= 1'b1;
						state_q <= ST_IDIG;
					end
				end
				ST_IDIG: begin
					if (idig_emit) begin
						if (slot_free) begin
							char_q  <= dtdt_pkg::CHAR_ZERO + {4'b0, top_digit};
							last_q  <= 1'b0;
							err_q   <= 1'b0;
							valid_q <= 1'b1;
							seen_q  <= 1'b1;
							if (idig_q == '0) begin
								state_q <= ST_DOT;
							end else begin
								idig_q <= idig_q - ICNT_W'(1);
							end
						end
					end else begin
						// leading zero: skip it
						idig_q <= idig_q - ICNT_W'(1);
					end
				end
				ST_DOT: begin
					if (slot_free) begin
						char_q  <= dtdt_pkg::CHAR_DOT;
						last_q  <= 1'b0;
						err_q   <= 1'b0;
						valid_q <= 1'b1;
						fcnt_q  <= '0;
						state_q <= ST_FNORM;
					end
				end
				ST_FNORM: begin
					if (!x_q[MW-1] && (x_q != '0) && (s_q < dtdt_pkg::SCALE_MAX)) begin
						x_q <= x_q << 1;
						s_q <= s_q + 11'd1;
					end else begin
						state_q <= ST_FMUL;
					end
				end
				ST_FMUL: begin
					keep_q  <= prod_sh[MW-1:0];
					rnd_q   <= rnd;
					s_q     <= s_q - {8'd0, k};
					state_q <= ST_FRND;
				end
				ST_FRND: begin
					if (slot_free) begin
						char_q  <= dtdt_pkg::CHAR_ZERO + {4'b0, digit};
						err_q   <= 1'b0;
						valid_q <= 1'b1;
						x_q     <= rem;
						s_q     <= s_adj;
						fcnt_q  <= fcnt_q + FCNT_W'(1);
						if (fcnt_q == FCNT_W'(FRACTION_DIGITS - 1)) begin
							last_q  <= 1'b1;
							state_q <= ST_IDLE;
						end else begin
							last_q  <= 1'b0;
							state_q <= ST_FNORM;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid = valid_q;
	assign character = char_q;
	assign last      = last_q;
	assign error     = err_q;

endmodule

FILE: hw/rtl/dtdt_bcd.sv
// ============================================================================
// dtdt_bcd: bit-serial binary to BCD converter
// Shift-add-3 conversion one bit per cycle; digits leave from the top.
// ============================================================================
module dtdt_bcd #(
	parameter int DIGITS = dtdt_pkg::INTEGER_DIGITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  dtdt_pkg::bcd_ctrl_t ctrl,
	output logic [3:0]          top_digit,
	output logic                overflow
);

	localparam int W = 4 * DIGITS;

	logic [W-1:0] bcd_q;
	logic [W-1:0] adj;
	logic         ovf_q;

	always_comb begin
		for (int i = 0; i < DIGITS; i++) begin
			if (bcd_q[4*i +: 4] >= 4'd5) begin
				adj[4*i +: 4] = bcd_q[4*i +: 4] + 4'd3;
			end else begin
				adj[4*i +: 4] = bcd_q[4*i +: 4];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bcd_q <= '0;
			ovf_q <= 1'b0;
		end else if (ctrl.clear) begin
			bcd_q <= '0;
			ovf_q <= 1'b0;
		end else if (ctrl.dabble) begin
			// a one leaving the top means the value needs one more digit
			bcd_q <= {adj[W-2:0], ctrl.bit_in};
			ovf_q <= ovf_q | adj[W-1];
		end else if (ctrl.pop) begin
			bcd_q <= bcd_q << 4;
		end
	end

	assign top_digit = bcd_q[W-1 -: 4];
	assign overflow  = ovf_q;

endmodule

FILE: verif/double_to_decimal_text_chk.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// double_to_decimal_text_chk: text predictor and comparator
// Watches both channels, predicts the characters for each accepted number
// in double precision and compares every output transaction in order.
// ----------------------------------------------------------------------------
module double_to_decimal_text_chk (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [63:0] value_bits,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [7:0]  character,
	input  logic        last,
	input  logic        error,
	output int          fail_count,
	output int          chars_owed
);

	localparam int INT_DIGITS  = dtdt_pkg::INTEGER_DIGITS_DEF;
	localparam int FRAC_DIGITS = dtdt_pkg::FRACTION_DIGITS_DEF;

	typedef struct packed {
		logic [7:0] ch;
		logic       fin;
		logic       err;
	} text_char_t;

	text_char_t owed_q[$];
	int         fails  = 0;
	int         owed_n = 0;

	assign fail_count = fails;
	assign chars_owed = owed_n;

	function automatic void queue_text(input logic [63:0] bits);
		logic [10:0]     expo;
		logic [52:0]     sig;
		longint unsigned ipart;
		real             mag, frac;
		int              d, sh;
		logic [3:0]      dig[INT_DIGITS];
		bit              started;
		expo = bits[62:52];
		if (expo == dtdt_pkg::EXP_SPECIAL) begin
			owed_q.push_back('{dtdt_pkg::CHAR_NONE, 1'b1, 1'b1});
			return;
		end
		mag = $bitstoreal({1'b0, bits[62:0]});
		if (mag >= 1.0e18) begin
			owed_q.push_back('{dtdt_pkg::CHAR_NONE, 1'b1, 1'b1});
			return;
		end
		// negative zero carries no sign
		if (bits[63] && bits[62:0] != 0)
			owed_q.push_back('{dtdt_pkg::CHAR_MINUS, 1'b0, 1'b0});
		// integer part by shifting the significand, exact truncation
		sig = {1'b1, bits[51:0]};
		if (expo < 11'd1023) ipart = 0;
		else begin
			sh = int'(expo) - 1023;
			ipart = (sh >= 52) ? (64'(sig) << (sh - 52)) : (64'(sig) >> (52 - sh));
		end
		frac = mag - real'(ipart);
		for (int k = 0; k < INT_DIGITS; k++) begin
			dig[k] = 4'(ipart % 10);
			ipart = ipart / 10;
		end
		started = 0;
		for (int k = INT_DIGITS - 1; k >= 0; k--) begin
			if (dig[k] != 0) started = 1;
			if (started || k == 0)
				owed_q.push_back('{dtdt_pkg::CHAR_ZERO + 8'(dig[k]), 1'b0, 1'b0});
		end
		owed_q.push_back('{dtdt_pkg::CHAR_DOT, 1'b0, 1'b0});
		for (int k = 0; k < FRAC_DIGITS; k++) begin
			frac = frac * 10.0;
			d = 0;
			while (d < 9 && frac >= real'(d + 1)) d++;
			frac = frac - real'(d);
			owed_q.push_back('{dtdt_pkg::CHAR_ZERO + 8'(d), k == FRAC_DIGITS - 1, 1'b0});
		end
	endfunction

	always @(posedge clk) begin
		text_char_t want;
		if (arst_n && in_valid && in_ready)
			queue_text(value_bits);
		if (arst_n && out_valid && out_ready) begin
			if (owed_q.size() == 0) begin
				fails++;
				$display("%0t: unexpected character %h last %b error %b",
					$time, character, last, error);
			end else begin
				want = owed_q.pop_front();
				if (want.ch !== character || want.fin !== last || want.err !== error) begin
					fails++;
					$display("%0t: expected char %h last %b error %b, got %h %b %b",
						$time, want.ch, want.fin, want.err, character, last, error);
				end
			end
		end
		owed_n <= owed_q.size();
	end
endmodule

FILE: verif/double_to_decimal_text_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// double_to_decimal_text_tb: double to decimal text testbench
// Drives directed and random binary64 patterns with random gaps on both
// channels; the checker predicts each character and counts mismatches.
// ----------------------------------------------------------------------------
module double_to_decimal_text_tb;
	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [63:0] value_bits;
	logic        out_valid;
	logic        out_ready;
	logic [7:0]  character;
	logic        last;
	logic        error;
	int          fail_count;
	int          chars_owed;
	bit          stim_done;
	bit          calm;    // stretch with no idling on either side

	double_to_decimal_text i_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .value_bits(value_bits),
		.out_valid(out_valid), .out_ready(out_ready),
		.character(character), .last(last), .error(error)
	);

	double_to_decimal_text_chk i_chk (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .value_bits(value_bits),
		.out_valid(out_valid), .out_ready(out_ready),
		.character(character), .last(last), .error(error),
		.fail_count(fail_count), .chars_owed(chars_owed)
	);

	always begin
		clk = 1'b1; #1;
		clk = 1'b0; #1;
	end

	// Mostly short gaps, now and then a long one.
	function automatic int pick_gap();
		if (calm) return 0;
		if ($urandom_range(0, 15) == 0) return $urandom_range(8, 40);
		return $urandom_range(0, 3);
	endfunction

	// Build a pattern: mostly convertible numbers, some denormals, some raw noise.
	function automatic logic [63:0] pick_value();
		int sel;
		sel = $urandom_range(0, 9);
		if (sel < 6)   // exponents around the full integer range
			return {1'($urandom), 11'($urandom_range(960, 1082)), $urandom, 20'($urandom)};
		if (sel == 6)  // small integer parts, short texts
			return {1'($urandom), 11'($urandom_range(1023, 1035)), $urandom, 20'($urandom)};
		if (sel == 7)  // denormals and tiny values
			return {1'($urandom), 11'($urandom_range(0, 2)), $urandom, 20'($urandom)};
		return {$urandom, $urandom};
	endfunction

	// Hold one transaction until the block takes it.
	task automatic send_value(input logic [63:0] v);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			@(negedge clk);
			in_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		in_valid   <= 1'b1;
		value_bits <= v;
		do @(posedge clk); while (!in_ready);
	endtask

	// Receiver side: random stalls, changed on the falling edge.
	initial begin
		int stall;
		out_ready = 1'b0;
		wait (arst_n);
		forever begin
			@(negedge clk);
			out_ready <= 1'b1;
			stall = pick_gap();
			if (stall > 0) begin
				@(negedge clk);
				out_ready <= 1'b0;
				repeat (stall - 1) @(negedge clk);
			end
		end
	end

	// Toggle between idling and calm stretches.
	initial begin
		calm = 0;
		forever begin
			repeat ($urandom_range(200, 2000)) @(posedge clk);
			calm = ($urandom_range(0, 3) == 0);
		end
	end

	initial begin
		logic [63:0] directed[$];
		arst_n     = 1'b0;
		in_valid   = 1'b0;
		value_bits = '0;
		stim_done  = 0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		directed = '{
			64'h0000_0000_0000_0000,  // zero
			64'h8000_0000_0000_0000,  // negative zero, no sign
			64'h3FF0_0000_0000_0000,  // 1.0
			64'hBFF8_0000_0000_0000,  // -1.5
			64'h3FB9_9999_9999_999A,  // 0.1
			64'h3FE0_0000_0000_0000,  // 0.5
			64'h3FEF_FFFF_FFFF_FFFF,  // just under one
			64'h4340_0000_0000_0000,  // 2^53
			64'h43AB_C16D_674E_C7FF,  // largest below 10^18
			64'hC3AB_C16D_674E_C7FF,
			64'h43AB_C16D_674E_C800,  // 10^18, overflow
			64'hC3AB_C16D_674E_C800,
			64'h7FF0_0000_0000_0000,  // infinity
			64'hFFF0_0000_0000_0000,
			64'h7FF8_0000_0000_0001,  // NaN
			64'hFFFF_FFFF_FFFF_FFFF,
			64'h7FEF_FFFF_FFFF_FFFF,  // largest finite
			64'h0000_0000_0000_0001,  // smallest denormal
			64'h800F_FFFF_FFFF_FFFF,
			64'h4024_0000_0000_0000,  // 10
			64'h4058_FFFF_FFFF_FFFF,  // just under 100
			64'hC08F_4CCC_CCCC_CCCD   // -1001.6
		};
		foreach (directed[i]) send_value(directed[i]);

		for (int n = 0; n < 460; n++) begin
			// pause once until the text so far has drained
			if (n == 200) begin
				@(negedge clk);
				in_valid <= 1'b0;
				wait (chars_owed == 0);
			end
			send_value(pick_value());
		end
		@(negedge clk);
		in_valid <= 1'b0;
		wait (chars_owed == 0);
		repeat (200) @(posedge clk);
		stim_done = 1;
	end

	initial begin
		wait (stim_done);
		if (fail_count == 0)
			$display("double_to_decimal_text_tb passed");
		else
			$display("double_to_decimal_text_tb failed");
		$finish;
	end

	initial begin
		#20ms;
		$display("double_to_decimal_text_tb failed");
		$finish;
	end
endmodule

FILE: double_to_decimal_text.f
hw/rtl/dtdt_pkg.sv
hw/rtl/dtdt_bcd.sv
hw/rtl/double_to_decimal_text.sv
verif/double_to_decimal_text_chk.sv
verif/double_to_decimal_text_tb.sv
